/* rtl/core/zssd_pkg.sv */
// ----------------------------------------------------------------------------
// Zero-suppressed sequence decoder package
// Shared types, codes and field constants for the sequence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package zssd_pkg;

    localparam int OFFSET_WIDTH_DEF = 20;

    localparam int WORD_W   = 16;
    localparam int ROW_W    = 7;
    localparam int PAD_W    = 8;
    localparam int IDX_W    = 8;
    localparam int BIN_W    = 9;
    localparam int LEN_W    = 10;
    localparam int SEQLEN_W = 5;
    localparam int OFS_W    = 20;
    localparam int LBIN_W   = 11;
    localparam int TDATA_W  = 64;

    localparam logic [PAD_W-1:0]  PAD_END      = 8'hFF;
    localparam logic [IDX_W-1:0]  IDX_MAX      = 8'hFF;
    localparam logic [LEN_W-1:0]  LEN_MAX      = 10'h3FF;
    localparam logic signed [LBIN_W-1:0] LBIN_NONE = -11'sd2;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_NEW     = 3'd1,
        ST_MERGED  = 3'd2,
        ST_END     = 3'd3,
        ST_NOHDR   = 3'd4,
        ST_BACK    = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_RUNNING = 2'd0,
        MODE_ENDED   = 2'd1,
        MODE_STOPPED = 2'd2
    } t_mode;

    // Field order matches the output tdata layout, lowest bits last here.
    typedef struct packed {
        t_status            status;
        logic               last_on_pad;
        logic [OFS_W-1:0]   adc_offset;
        logic [LEN_W-1:0]   seq_length;
        logic [BIN_W-1:0]   start_bin;
        logic [IDX_W-1:0]   seq_index;
        logic [PAD_W-1:0]   pad_number;
        logic [ROW_W-1:0]   row_number;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/zero_suppressed_sequence_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Zero-suppressed sequence decoder unit
// Decodes header and sequence words of one readout bank into sequence
// records with row, pad, index, start bin, merged length and ADC offset.
//
// Usage:
//   Input beats carry one 16-bit bank word in tdata; tuser is the bank start
//   flag, which clears all per-bank state before that word is handled.
//   Every input beat gives exactly one output beat. Output tuser holds the
//   status code, tlast the last-on-pad flag of a sequence word.
//   The output beat is registered, and one input beat is taken every cycle
//   while the skid register is empty: the whole decode is one pass of
//   compares and adds between the input port and the output register.
//   The output side has a main register and a skid register, so an input
//   beat is still taken in the cycle the receiver first stalls; input tready
//   drops only while the skid register is occupied.
//   After reset the decoder is in the running mode with no header seen and
//   both output registers empty. An end marker or a decode error makes
//   every later word report as ignored until a beat with bank start set.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_suppressed_sequence_decoder_unit #(
    parameter int OFFSET_WIDTH = zssd_pkg::OFFSET_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Slave side
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [zssd_pkg::WORD_W-1:0]   i_s_tdata,   // [15:0] data_word
    input  wire logic                          i_s_tuser,   // [0] bank_start
    // Master side
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [6:0] row_number, [14:7] pad_number, [22:15] seq_index,
    // [31:23] start_bin, [41:32] seq_length, [61:42] adc_offset, [63:62] zero
    output logic [zssd_pkg::TDATA_W-1:0]       o_m_tdata,
    output logic [2:0]                         o_m_tuser,   // [2:0] status
    output logic                               o_m_tlast    // last_on_pad
);

    import zssd_pkg::*;

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]         r_row,        n_row;
    logic [PAD_W-1:0]         r_pad,        n_pad;
    logic                     r_have_hdr,   n_have_hdr;
    logic signed [LBIN_W-1:0] r_last_bin,   n_last_bin;
    logic [BIN_W-1:0]         r_prev_start, n_prev_start;
    logic [IDX_W-1:0]         r_seq_cnt,    n_seq_cnt;
    logic [BIN_W-1:0]         r_open_start, n_open_start;
    logic [LEN_W-1:0]         r_open_len,   n_open_len;
    logic [OFFSET_WIDTH-1:0]  r_open_ofs,   n_open_ofs;
    logic [OFFSET_WIDTH-1:0]  r_adc_pos,    n_adc_pos;
    t_mode                    r_mode,       n_mode;

    t_result                  r_out, r_skid, n_result;
    logic                     r_out_valid, r_skid_valid;

    logic push, pop;

    // Word fields
    logic                     w_is_hdr;
    logic [ROW_W-1:0]         w_row;
    logic [PAD_W-1:0]         w_pad;
    logic [BIN_W-1:0]         w_start;
    logic [SEQLEN_W-1:0]      w_len;
    logic                     w_last;

    assign w_is_hdr = i_s_tdata[15];
    assign w_row    = i_s_tdata[14:8];
    assign w_pad    = i_s_tdata[7:0];
    assign w_start  = i_s_tdata[14:6];
    assign w_last   = i_s_tdata[5];
    assign w_len    = i_s_tdata[4:0];

    assign o_s_tready = !r_skid_valid;
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = r_out_valid && i_m_tready;

    // ------------------------------------------------------------------
    // Single-pass decode of one word
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [LBIN_W:0] start_ext;
        logic signed [LBIN_W:0] follow_bin;
        logic [LEN_W:0]         len_sum;
        logic [31:0]            ofs_wide;

        // Bank start clears state before the word is looked at.
        if (i_s_tuser) begin
            n_row        = '0;
            n_pad        = '0;
            n_have_hdr   = 1'b0;
            n_last_bin   = LBIN_NONE;
            n_prev_start = '0;
            n_seq_cnt    = '0;
            n_open_start = '0;
            n_open_len   = '0;
            n_open_ofs   = '0;
            n_adc_pos    = '0;
            n_mode       = MODE_RUNNING;
        end else begin
            n_row        = r_row;
            n_pad        = r_pad;
            n_have_hdr   = r_have_hdr;
            n_last_bin   = r_last_bin;
            n_prev_start = r_prev_start;
            n_seq_cnt    = r_seq_cnt;
            n_open_start = r_open_start;
            n_open_len   = r_open_len;
            n_open_ofs   = r_open_ofs;
            n_adc_pos    = r_adc_pos;
            n_mode       = r_mode;
        end

        start_ext  = $signed({3'b000, w_start});
        follow_bin = $signed({n_last_bin[LBIN_W-1], n_last_bin}) + 12'sd1;
        len_sum    = {1'b0, n_open_len} + {{(LEN_W-SEQLEN_W+1){1'b0}}, w_len};
        ofs_wide   = '0;

        n_result = '0;
        n_result.status = ST_IGNORED;

        if (n_mode == MODE_RUNNING) begin
            if (w_is_hdr) begin
                if (w_pad == PAD_END) begin
                    n_mode                = MODE_ENDED;
                    n_result.status       = ST_END;
                    n_result.row_number   = w_row;
                    n_result.pad_number   = w_pad;
                end else begin
                    n_row                 = w_row;
                    n_pad                 = w_pad;
                    n_have_hdr            = 1'b1;
                    n_seq_cnt             = '0;
                    n_prev_start          = '0;
                    n_last_bin            = LBIN_NONE;
                    n_result.status       = ST_HEADER;
                    n_result.row_number   = w_row;
                    n_result.pad_number   = w_pad;
                end
            end else if (!n_have_hdr) begin
                n_mode                = MODE_STOPPED;
                n_result.status       = ST_NOHDR;
                n_result.row_number   = n_row;
                n_result.pad_number   = n_pad;
            end else if (w_start < n_prev_start) begin
                n_mode                = MODE_STOPPED;
                n_result.status       = ST_BACK;
                n_result.row_number   = n_row;
                n_result.pad_number   = n_pad;
            end else begin
                if (start_ext > follow_bin) begin
                    // Gap to the previous sequence: open a new one.
                    n_open_start       = w_start;
                    n_open_len         = {{(LEN_W-SEQLEN_W){1'b0}}, w_len};
                    n_open_ofs         = n_adc_pos;
                    n_result.seq_index = n_seq_cnt;
                    if (n_seq_cnt != IDX_MAX) begin
                        n_seq_cnt = n_seq_cnt + 1'b1;
                    end
                    n_result.status    = ST_NEW;
                end else begin
                    n_open_len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
                    n_result.seq_index = (n_seq_cnt != '0) ? n_seq_cnt - 1'b1 : '0;
                    n_result.status    = ST_MERGED;
                end

                ofs_wide = 32'(n_open_ofs);

                n_result.row_number  = n_row;
                n_result.pad_number  = n_pad;
                n_result.start_bin   = n_open_start;
                n_result.seq_length  = n_open_len;
                n_result.adc_offset  = ofs_wide[OFS_W-1:0];
                n_result.last_on_pad = w_last;

                n_adc_pos    = n_adc_pos + OFFSET_WIDTH'(w_len);
                n_last_bin   = $signed({2'b00, w_start})
                             + $signed({6'b000000, w_len}) - 11'sd1;
                n_prev_start = w_start;

                if (w_last) begin
                    n_pad        = n_pad + 1'b1;
                    n_seq_cnt    = '0;
                    n_last_bin   = LBIN_NONE;
                    n_prev_start = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_pad        <= '0;
            r_have_hdr   <= 1'b0;
            r_last_bin   <= LBIN_NONE;
            r_prev_start <= '0;
            r_seq_cnt    <= '0;
            r_open_start <= '0;
            r_open_len   <= '0;
            r_open_ofs   <= '0;
            r_adc_pos    <= '0;
            r_mode       <= MODE_RUNNING;
        end else if (push) begin
            r_row        <= n_row;
            r_pad        <= n_pad;
            r_have_hdr   <= n_have_hdr;
            r_last_bin   <= n_last_bin;
            r_prev_start <= n_prev_start;
            r_seq_cnt    <= n_seq_cnt;
            r_open_start <= n_open_start;
            r_open_len   <= n_open_len;
            r_open_ofs   <= n_open_ofs;
            r_adc_pos    <= n_adc_pos;
            r_mode       <= n_mode;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!push) begin
                r_out_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= n_result;
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last_on_pad;
    assign o_m_tdata  = {2'b00, r_out.adc_offset, r_out.seq_length, r_out.start_bin,
                         r_out.seq_index, r_out.pad_number, r_out.row_number};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_count_needs_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_cnt != '0) |-> r_have_hdr)
        else $error("sequence count is nonzero without a header");

    a_start_needs_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_start != '0) |-> r_have_hdr)
        else $error("previous start is set without a header");

endmodule

`default_nettype wire
